/* src/etot_pkg.sv */
// Shared constants and types for the Euler totient block.
// Holds the default value width and the control state encoding.
// No dependencies.
package etot_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FMUL,
    ST_OUT
  } etot_state_t;

endpackage

/* src/etot_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Gives quotient and remainder of an unsigned division. Depends on etot_pkg.
module etot_div
  import etot_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quot,
  output logic [VALUE_WIDTH-1:0] rem
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy_r;
  logic [CW-1:0]          cnt_r;
  logic [VALUE_WIDTH-1:0] q_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] dvs_r;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   trial;

  assign shifted = {rem_r, q_r[VALUE_WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign done    = busy_r && (cnt_r == '0);
  assign quot    = q_r;
  assign rem     = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(VALUE_WIDTH);
    end else if (busy_r) begin
      if (done) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r && !done) begin
      if (!trial[VALUE_WIDTH]) begin
        rem_r <= trial[VALUE_WIDTH-1:0];
        q_r   <= {q_r[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem_r <= shifted[VALUE_WIDTH-1:0];
        q_r   <= {q_r[VALUE_WIDTH-2:0], 1'b0};
      end
    end
  end

endmodule

/* src/etot_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// The product is truncated to the value width. Depends on etot_pkg.
module etot_mul
  import etot_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] op_a,
  input  logic [VALUE_WIDTH-1:0] op_b,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] prod
);

  logic                   busy_r;
  logic [VALUE_WIDTH-1:0] mcand_r;
  logic [VALUE_WIDTH-1:0] mplier_r;
  logic [VALUE_WIDTH-1:0] prod_r;

  assign done = busy_r && (mplier_r == '0);
  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= op_a;
      mplier_r <= op_b;
      prod_r   <= '0;
    end else if (busy_r && !done) begin
      if (mplier_r[0]) begin
        prod_r <= prod_r + mcand_r;
      end
      mcand_r  <= {mcand_r[VALUE_WIDTH-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[VALUE_WIDTH-1:1]};
    end
  end

endmodule

/* src/euler_totient_trial_division.sv */
// Euler totient by trial division: top level with control sequencer.
// Instantiates etot_div and etot_mul; depends on etot_pkg.
//
// Usage: present an unsigned value on in_value with in_valid; it is taken
// in a beat when in_valid and in_ready are both high. When the search ends the
// out_ channel carries totient phi(value), held with out_valid until
// out_ready takes it. An input of zero gives zero.
// One item is worked on at a time: in_ready is high only while the block is
// idle, and it stays low while a finished result waits for the receiver.
// Each trial divisor costs one bit-serial division, and each factor found
// adds a shift-add multiply. The worst case is a prime near 2^VALUE_WIDTH,
// for which about 2^(VALUE_WIDTH/2) candidate divisors are tried.
// The divider is the limiting unit.
// Reset returns the block to idle and drops any result in flight.
module euler_totient_trial_division
  import etot_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_totient
);

  etot_state_t            state_r, state_nxt;
  logic                   inner_r, inner_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] rest_r, rest_nxt;
  logic [VALUE_WIDTH-1:0] p_r, p_nxt;

  logic                   div_start, div_done;
  logic [VALUE_WIDTH-1:0] div_quot, div_rem;
  logic                   mul_start, mul_done;
  logic [VALUE_WIDTH-1:0] mul_b, mul_prod;

  etot_div #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest_nxt),
    .divisor  (p_nxt),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  etot_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (acc_r),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = (state_r == ST_OUT);
  assign out_totient = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      inner_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inner_r <= inner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rest_r <= rest_nxt;
    p_r    <= p_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    inner_nxt = inner_r;
    acc_nxt   = acc_r;
    rest_nxt  = rest_r;
    p_nxt     = p_r;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_b     = p_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_value == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            acc_nxt   = VALUE_WIDTH'(1);
            rest_nxt  = in_value;
            p_nxt     = VALUE_WIDTH'(2);
            inner_nxt = 1'b0;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (!inner_r && (p_r > div_quot)) begin
            if (rest_r > VALUE_WIDTH'(1)) begin
              mul_b     = rest_r - VALUE_WIDTH'(1);
              mul_start = 1'b1;
              state_nxt = ST_FMUL;
            end else begin
              state_nxt = ST_OUT;
            end
          end else if (div_rem == '0) begin
            rest_nxt  = div_quot;
            mul_b     = inner_r ? p_r : (p_r - VALUE_WIDTH'(1));
            mul_start = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            p_nxt     = p_r + VALUE_WIDTH'(1);
            inner_nxt = 1'b0;
            div_start = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          acc_nxt   = mul_prod;
          inner_nxt = 1'b1;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_FMUL: begin
        if (mul_done) begin
          acc_nxt   = mul_prod;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* tb/sv/euler_totient_trial_division_test.sv */
// Self-checking testbench for euler_totient_trial_division.
// Drives values over valid/ready and checks each totient against an in-bench predictor.
// Depends on etot_pkg and the block itself.
`timescale 1ns / 1ps

module euler_totient_trial_division_test
  import etot_pkg::*;
();

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned RANDOM_ITEMS = 100;

  typedef struct {
    bit [VW-1:0] value;
    bit [VW-1:0] totient;
  } totient_entry_t;

  class totient_board;
    totient_entry_t expected_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function bit [VW-1:0] totient_of(bit [VW-1:0] n);
      bit [VW-1:0] acc;
      bit [VW-1:0] rest;
      bit [VW-1:0] p;
      if (n == 0) return '0;
      acc = 1;
      rest = n;
      for (p = 2; p <= rest / p; p++) begin
        if (rest % p == 0) begin
          rest = rest / p;
          acc = acc * (p - 1);
          while (rest % p == 0) begin
            rest = rest / p;
            acc = acc * p;
          end
        end
      end
      if (rest > 1) acc = acc * (rest - 1);
      return acc;
    endfunction

    task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    function void note_value(bit [VW-1:0] v);
      totient_entry_t e;
      e.value = v;
      e.totient = totient_of(v);
      expected_q = {expected_q, e};
    endfunction

    task check_totient(logic [VW-1:0] got);
      totient_entry_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("totient %0d arrived with nothing pending", got));
      end else begin
        e = expected_q.pop_front();
        if (got !== e.totient)
          report($sformatf("value %0d: totient %0d, wanted %0d", e.value, got, e.totient));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [VW-1:0] in_value = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VW-1:0] out_totient;

  totient_board board = new();
  int  stall_left = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;

  bit [VW-1:0] directed_values [19] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd97, 32'd1000,
    32'd63001, 32'd65536, 32'd1048573, 32'd4294955008, 32'd223092870,
    32'd3486784401, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
  };

  euler_totient_trial_division #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_totient(out_totient)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 20);
    else return $urandom_range(50, 200);
  endfunction

  // Products of small factors reach the top bits while trial division stays short.
  function automatic bit [VW-1:0] smooth_value();
    longint unsigned prod;
    int unsigned f;
    int k;
    prod = 1;
    for (k = 0; k < 40; k++) begin
      f = $urandom_range(2, 60);
      if (prod * f <= 64'hFFFF_FFFF) prod = prod * f;
    end
    return prod[VW-1:0];
  endfunction

  function automatic bit [VW-1:0] random_value();
    int r;
    bit [VW-1:0] odd;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 1023);
    else if (r < 65) begin
      odd = $urandom_range(1, 4095) | 1;
      return odd << $urandom_range(0, VW - 1);
    end
    else if (r < 80) return smooth_value();
    else if (r < 95) return $urandom_range(0, 65535);
    else return $urandom_range(0, (1 << 20) - 1);
  endfunction

  task automatic send_value(input bit [VW-1:0] v, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_value(v);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Each result beat is checked before out_ready is redrawn for the next edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_totient(out_totient);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left <= gap_len();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_values[i]) send_value(directed_values[i], gap_len());
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 40 && i < 60);
      send_value(random_value(), quiet ? 0 : gap_len());
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.pending() != 0) board.report("expected totients left over");
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/etot_pkg.sv
src/etot_div.sv
src/etot_mul.sv
src/euler_totient_trial_division.sv
tb/sv/euler_totient_trial_division_test.sv
